>>> design/mcfd_pkg.sv
// Shared types, constants and decode helpers of the motor command frame decoder.
package mcfd_pkg;

  // Frame layout
  localparam int unsigned WINDOW_DEPTH = 13;
  localparam int unsigned PAYLOAD_LEN  = 9;
  localparam int unsigned MOTOR_COUNT  = 4;

  // Marker bytes
  localparam logic [7:0] HEAD_0 = 8'hA0;
  localparam logic [7:0] HEAD_1 = 8'hA5;
  localparam logic [7:0] TAIL_0 = 8'hC0;
  localparam logic [7:0] TAIL_1 = 8'hC5;

  // Direction and pin codes
  localparam logic [7:0] CODE_LOW  = 8'h0F;
  localparam logic [7:0] CODE_HIGH = 8'hF0;

  // Register reset value
  localparam logic [MOTOR_COUNT-1:0] SWAP_MASK_RESET = 4'd6;

  // Nine payload bytes of an accepted frame, byte 0 first
  typedef logic [PAYLOAD_LEN-1:0][7:0] payload_t;

  // Compare values of one bridge
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
  } duty_pair_t;

  // Route the duty to one channel by code and polarity bit, or to none for other codes
  function automatic duty_pair_t drive_motor(input logic [7:0] code,
                                             input logic [7:0] duty,
                                             input logic       swap);
    duty_pair_t       res;
    logic       [7:0] code_a;
    logic       [7:0] code_b;
    code_a = swap ? CODE_HIGH : CODE_LOW;
    code_b = swap ? CODE_LOW : CODE_HIGH;
    res    = '0;
    if (code == code_a) begin
      res.a = duty;
    end else if (code == code_b) begin
      res.b = duty;
    end
    return res;
  endfunction

endpackage

>>> design/mcfd_if.sv
// Handshake interfaces of the received byte stream and the command stream.
interface mcfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mcfd_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] m0_duty_a;
  logic [7:0] m0_duty_b;
  logic [7:0] m1_duty_a;
  logic [7:0] m1_duty_b;
  logic [7:0] m2_duty_a;
  logic [7:0] m2_duty_b;
  logic [7:0] m3_duty_a;
  logic [7:0] m3_duty_b;
  logic       pin_one_level;
  logic       pin_two_level;

  modport source (
    output valid, input ready,
    output m0_duty_a, output m0_duty_b, output m1_duty_a, output m1_duty_b,
    output m2_duty_a, output m2_duty_b, output m3_duty_a, output m3_duty_b,
    output pin_one_level, output pin_two_level
  );
  modport sink (
    input valid, output ready,
    input m0_duty_a, input m0_duty_b, input m1_duty_a, input m1_duty_b,
    input m2_duty_a, input m2_duty_b, input m3_duty_a, input m3_duty_b,
    input pin_one_level, input pin_two_level
  );
endinterface

>>> design/mcfd_front.sv
// Front end: sliding byte window, frame check and push of accepted payloads.
module mcfd_front (
  input  logic              clk,
  input  logic              rst,
  mcfd_byte_if.sink         rx,
  output logic              push,
  output mcfd_pkg::payload_t push_data,
  input  logic              push_ready
);
  import mcfd_pkg::*;

  logic [WINDOW_DEPTH-1:0][7:0] window;   // oldest byte at index 0
  logic                         take;
  logic [7:0]                   check;
  logic                         frame_ok;

  // Accept whenever the queue can hold a frame
  assign rx.ready = push_ready;
  assign take     = rx.valid && push_ready;

  // XOR of the nine payload bytes held at window positions 2..10
  always_comb begin
    check = '0;
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      check = check ^ window[2 + i];
    end
  end

  // Frame check on the window plus the byte now arriving
  assign frame_ok = (window[0] == HEAD_0) && (window[1] == HEAD_1) &&
                    (window[12] == TAIL_0) && (rx.rx_byte == TAIL_1) &&
                    (window[11] == check);

  assign push = take && frame_ok;

  always_comb begin
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      push_data[i] = window[2 + i];
    end
  end

  // Window shift, one byte per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (take) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        window[i] <= window[i + 1];
      end
      window[WINDOW_DEPTH-1] <= rx.rx_byte;
    end
  end

endmodule

>>> design/mcfd_queue.sv
// Short FIFO of accepted frame payloads between the front and back ends.
module mcfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mcfd_pkg::payload_t push_data,
  output logic               push_ready,
  output logic               head_valid,
  output mcfd_pkg::payload_t head_data,
  input  logic               pop
);
  import mcfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  payload_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_FULL);
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/mcfd_back.sv
// Back end: direction decode, pin level state and the output register.
module mcfd_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [mcfd_pkg::MOTOR_COUNT-1:0]     cfg_wr_data,
  input  logic                                 head_valid,
  input  mcfd_pkg::payload_t                   head_data,
  output logic                                 pop,
  mcfd_cmd_if.source                           cmd
);
  import mcfd_pkg::*;

  logic [MOTOR_COUNT-1:0] swap_mask;
  logic [1:0]             pin_levels;       // bit 0 pin one, bit 1 pin two
  logic [1:0]             pin_levels_next;
  duty_pair_t             duty [MOTOR_COUNT];
  logic                   out_valid;
  logic                   load;

  // Polarity register
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_mask <= SWAP_MASK_RESET;
    end else if (cfg_wr_en) begin
      swap_mask <= cfg_wr_data;
    end
  end

  // Per-motor channel selection
  always_comb begin
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      duty[m] = drive_motor(head_data[2 * m], head_data[2 * m + 1], swap_mask[m]);
    end
  end

  // Pin code: known codes set the levels, anything else keeps them
  always_comb begin
    priority if (head_data[8] == CODE_HIGH) begin
      pin_levels_next = 2'b01;
    end else if (head_data[8] == CODE_LOW) begin
      pin_levels_next = 2'b10;
    end else begin
      pin_levels_next = pin_levels;
    end
  end

  // Take the next frame when the output register is free or being emptied
  assign load = head_valid && (!out_valid || cmd.ready);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pin_levels <= '0;
    end else begin
      if (load) begin
        out_valid  <= 1'b1;
        pin_levels <= pin_levels_next;
      end else if (cmd.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      cmd.m0_duty_a     <= duty[0].a;
      cmd.m0_duty_b     <= duty[0].b;
      cmd.m1_duty_a     <= duty[1].a;
      cmd.m1_duty_b     <= duty[1].b;
      cmd.m2_duty_a     <= duty[2].a;
      cmd.m2_duty_b     <= duty[2].b;
      cmd.m3_duty_a     <= duty[3].a;
      cmd.m3_duty_b     <= duty[3].b;
      cmd.pin_one_level <= pin_levels_next[0];
      cmd.pin_two_level <= pin_levels_next[1];
    end
  end

  assign cmd.valid = out_valid;

endmodule

>>> design/motor_command_frame_decoder.sv
// Top level of the motor command frame decoder.
// Takes one received byte per transaction on rx and checks every 14-byte span
// ending on that byte for header A0 A5, tail C0 C5 and an XOR check byte;
// each matching frame yields one command transaction on cmd with the four
// bridge compare pairs and the two pin levels. Bytes are taken one per cycle;
// a byte that completes a frame enters a QUEUE_DEPTH-entry queue ahead of the
// decoder and output register, so rx stalls only while that queue is full.
// With the queue empty and the output register free, a frame's payload passes
// through the queue and then the output register to become valid on cmd.
// cfg_wr_en/cfg_wr_data write the per-motor polarity mask (reset 6) and must
// only be used while no frame is in flight.
module motor_command_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [mcfd_pkg::MOTOR_COUNT-1:0] cfg_wr_data,
  mcfd_byte_if.sink                        rx,
  mcfd_cmd_if.source                       cmd
);
  import mcfd_pkg::*;

  logic     push;
  logic     push_ready;
  payload_t push_data;
  logic     head_valid;
  payload_t head_data;
  logic     pop;

  // Window and frame check
  mcfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // Frame queue
  mcfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  // Decode and output
  mcfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .pop         (pop),
    .cmd         (cmd)
  );

endmodule

>>> dv/tb_motor_command_frame_decoder.sv
// Self-checking testbench of the motor command frame decoder: table-driven frames, then random.
module tb_motor_command_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import mcfd_pkg::*;

  localparam int unsigned FRAME_LEN      = 14;
  localparam int unsigned PHASE_BYTES    = 190;
  localparam int unsigned PHASE_COUNT    = 5;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // How a frame is damaged on its way out
  typedef enum int unsigned {
    FRM_GOOD,
    FRM_BAD_HEAD,
    FRM_BAD_CHECK,
    FRM_BAD_TAIL
  } frame_kind_e;

  // One decoded command as it leaves the block
  typedef struct packed {
    duty_pair_t [MOTOR_COUNT-1:0] bridge;
    logic                         pin_one;
    logic                         pin_two;
  } cmd_t;

  // Directed frame: fields listed motor 3 first
  typedef struct {
    frame_kind_e                  kind;
    logic [MOTOR_COUNT-1:0][7:0]  dir_code;
    logic [MOTOR_COUNT-1:0][7:0]  duty;
    logic [7:0]                   pin_code;
    bit                           typed;
    cmd_t                         want;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [MOTOR_COUNT-1:0] cfg_wr_data;

  mcfd_byte_if rx_bus ();
  mcfd_cmd_if  cmd_bus ();

  motor_command_frame_decoder u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx_bus),
    .cmd         (cmd_bus)
  );

  always #6 clk = ~clk;

  // Decoder shadow state
  logic [7:0]             rx_window [WINDOW_DEPTH];
  logic [1:0]             pin_state;
  logic [MOTOR_COUNT-1:0] swap_mask;

  cmd_t pending_cmds [$];
  cmd_t predicted_cmd;
  cmd_t oldest_cmd;

  int unsigned bytes_taken;
  int unsigned frames_predicted;
  int unsigned frames_checked;
  int unsigned mask_writes;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          gaps_on;
  bit          stalls_on;

  // Directed frames, all under the reset swap mask
  frame_row_t directed_rows [9] = '{
    // unknown direction and pin codes: everything off, pins still at reset
    '{FRM_GOOD, {4{8'h00}}, {4{8'hFF}}, 8'h00, 1'b1, {64'h0, 1'b0, 1'b0}},
    // all low codes, full duty, pin code high
    '{FRM_GOOD, {4{CODE_LOW}}, {4{8'hFF}}, CODE_HIGH, 1'b1,
      {64'hFF00_00FF_00FF_FF00, 1'b1, 1'b0}},
    // all high codes, zero duty, pin code low
    '{FRM_GOOD, {4{CODE_HIGH}}, {4{8'h00}}, CODE_LOW, 1'b1, {64'h0, 1'b0, 1'b1}},
    // all high codes, full duty, unknown pin code keeps the levels
    '{FRM_GOOD, {4{CODE_HIGH}}, {4{8'hFF}}, 8'h55, 1'b1,
      {64'h00FF_FF00_FF00_00FF, 1'b0, 1'b1}},
    // mixed codes, near-miss codes on motors 2 and 3
    '{FRM_GOOD, {8'hF1, 8'h0E, CODE_HIGH, CODE_LOW}, {8'hFE, 8'h7F, 8'h80, 8'h01},
      CODE_HIGH, 1'b0, '0},
    '{FRM_BAD_CHECK, {4{CODE_LOW}}, {4{8'h5A}}, CODE_LOW, 1'b0, '0},
    '{FRM_BAD_HEAD, {4{CODE_HIGH}}, {4{8'hA5}}, CODE_LOW, 1'b0, '0},
    '{FRM_BAD_TAIL, {4{CODE_LOW}}, {4{8'hC3}}, CODE_LOW, 1'b0, '0},
    '{FRM_GOOD, {CODE_HIGH, CODE_LOW, CODE_HIGH, CODE_LOW}, {8'h80, 8'h7F, 8'h01, 8'hFE},
      CODE_LOW, 1'b0, '0}
  };

  // XOR of the nine payload bytes
  function automatic logic [7:0] check_byte(input payload_t pl);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      acc ^= pl[i];
    end
    return acc;
  endfunction

  // Slide one byte into the shadow window; returns 1 when a frame completes
  function automatic bit decode_byte(input logic [7:0] b, output cmd_t res);
    logic [7:0] frame [FRAME_LEN];
    logic [7:0] acc;
    logic [7:0] code;
    logic [7:0] duty;
    bit         a_chan;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      frame[i] = rx_window[i];
    end
    frame[FRAME_LEN-1] = b;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      rx_window[i] = frame[i+1];
    end
    acc = 8'h00;
    for (int i = 2; i < 2 + PAYLOAD_LEN; i++) begin
      acc ^= frame[i];
    end
    res = '0;
    if (frame[0] != HEAD_0 || frame[1] != HEAD_1 || frame[12] != TAIL_0 ||
        frame[13] != TAIL_1 || frame[11] != acc) begin
      return 1'b0;
    end
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      code = frame[2 + 2*m];
      duty = frame[3 + 2*m];
      // low code goes to channel a unless the polarity bit flips it
      a_chan = (code == CODE_LOW) ^ swap_mask[m];
      if (code == CODE_LOW || code == CODE_HIGH) begin
        if (a_chan) res.bridge[m].a = duty;
        else        res.bridge[m].b = duty;
      end
    end
    if (frame[10] == CODE_HIGH) begin
      pin_state = 2'b01;
    end else if (frame[10] == CODE_LOW) begin
      pin_state = 2'b10;
    end
    res.pin_one = pin_state[0];
    res.pin_two = pin_state[1];
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Random payload biased towards the two valid codes and duty extremes
  function automatic payload_t rand_payload();
    payload_t   pl;
    int unsigned r;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      r = $urandom_range(0, 9);
      if (r < 4)       pl[2*m] = CODE_LOW;
      else if (r < 8)  pl[2*m] = CODE_HIGH;
      else if (r == 8) pl[2*m] = CODE_LOW ^ (8'h01 << $urandom_range(0, 7));
      else             pl[2*m] = 8'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0)      pl[2*m+1] = 8'h00;
      else if (r == 1) pl[2*m+1] = 8'hFF;
      else             pl[2*m+1] = 8'($urandom);
    end
    r = $urandom_range(0, 9);
    if (r < 4)      pl[8] = CODE_LOW;
    else if (r < 8) pl[8] = CODE_HIGH;
    else            pl[8] = 8'($urandom);
    return pl;
  endfunction

  // One byte transaction, with an optional gap ahead of it; returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      rx_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    rx_bus.rx_byte <= b;
    rx_bus.valid   <= 1'b1;
    do @(posedge clk); while (!rx_bus.ready);
    @(negedge clk);
  endtask

  // Frame on the wire, possibly damaged, possibly cut short
  task automatic send_frame(input payload_t pl, input frame_kind_e kind, input int nbytes);
    logic [7:0] frame [FRAME_LEN];
    logic [7:0] flip;
    flip = 8'h01 << $urandom_range(0, 7);
    frame[0]  = HEAD_0;
    frame[1]  = HEAD_1;
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      frame[2+i] = pl[i];
    end
    frame[11] = check_byte(pl);
    frame[12] = TAIL_0;
    frame[13] = TAIL_1;
    case (kind)
      FRM_BAD_HEAD: begin
        frame[$urandom_range(0, 1)] ^= flip;
      end
      FRM_BAD_CHECK: begin
        frame[11] ^= 8'($urandom_range(1, 255));
      end
      FRM_BAD_TAIL: begin
        frame[$urandom_range(12, 13)] ^= flip;
      end
      default: ;
    endcase
    for (int i = 0; i < nbytes; i++) begin
      send_byte(frame[i]);
    end
  endtask

  // Two good frames sharing bytes: the second header sits in the first payload
  task automatic send_overlap_pair();
    payload_t first;
    payload_t second;
    first    = rand_payload();
    first[7] = HEAD_0;
    first[8] = HEAD_1;
    send_frame(first, FRM_GOOD, FRAME_LEN);
    second    = rand_payload();
    second[0] = check_byte(first);
    second[1] = TAIL_0;
    second[2] = TAIL_1;
    for (int i = 3; i < PAYLOAD_LEN; i++) begin
      send_byte(second[i]);
    end
    send_byte(check_byte(second));
    send_byte(TAIL_0);
    send_byte(TAIL_1);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  // Reprogram the polarity mask once nothing is in flight
  task automatic reprogram(input logic [MOTOR_COUNT-1:0] mask);
    rx_bus.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    swap_mask = mask;
    mask_writes++;
  endtask

  // Predict on every byte taken, check every command handed out
  always @(posedge clk) begin
    if (!rst) begin
      if (rx_bus.valid && rx_bus.ready) begin
        bytes_taken++;
        if (decode_byte(rx_bus.rx_byte, predicted_cmd)) begin
          pending_cmds.push_back(predicted_cmd);
          frames_predicted++;
        end
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        if (pending_cmds.size() == 0) begin
          $error("command transaction with no frame pending");
          mismatch_count++;
        end else begin
          oldest_cmd = pending_cmds.pop_front();
          frames_checked++;
          check_field("m0_duty_a", oldest_cmd.bridge[0].a, cmd_bus.m0_duty_a);
          check_field("m0_duty_b", oldest_cmd.bridge[0].b, cmd_bus.m0_duty_b);
          check_field("m1_duty_a", oldest_cmd.bridge[1].a, cmd_bus.m1_duty_a);
          check_field("m1_duty_b", oldest_cmd.bridge[1].b, cmd_bus.m1_duty_b);
          check_field("m2_duty_a", oldest_cmd.bridge[2].a, cmd_bus.m2_duty_a);
          check_field("m2_duty_b", oldest_cmd.bridge[2].b, cmd_bus.m2_duty_b);
          check_field("m3_duty_a", oldest_cmd.bridge[3].a, cmd_bus.m3_duty_a);
          check_field("m3_duty_b", oldest_cmd.bridge[3].b, cmd_bus.m3_duty_b);
          check_field("pin_one_level", {7'd0, oldest_cmd.pin_one},
                      {7'd0, cmd_bus.pin_one_level});
          check_field("pin_two_level", {7'd0, oldest_cmd.pin_two},
                      {7'd0, cmd_bus.pin_two_level});
        end
      end
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk) begin
    if (rst || (rx_bus.valid && rx_bus.ready) || (cmd_bus.valid && cmd_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Command sink: random stall bursts
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    cmd_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        cmd_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        cmd_bus.ready <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        cmd_bus.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        cmd_bus.ready <= 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    payload_t                pl;
    int unsigned             prev_frames;
    int unsigned             goal;
    int unsigned             r;
    logic [MOTOR_COUNT-1:0]  mask;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = 8'h00;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      rx_window[i] = 8'h00;
    end
    pin_state        = 2'b00;
    swap_mask        = SWAP_MASK_RESET;
    bytes_taken      = 0;
    frames_predicted = 0;
    frames_checked   = 0;
    mask_writes      = 0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Startup: a tail against the zero window must not decode
    send_byte(TAIL_0);
    send_byte(TAIL_1);

    // Directed table
    foreach (directed_rows[k]) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        pl[2*m]   = directed_rows[k].dir_code[m];
        pl[2*m+1] = directed_rows[k].duty[m];
      end
      pl[8]       = directed_rows[k].pin_code;
      prev_frames = frames_predicted;
      send_frame(pl, directed_rows[k].kind, FRAME_LEN);
      if (directed_rows[k].typed) begin
        if (frames_predicted == prev_frames + 1) begin
          pending_cmds[$] = directed_rows[k].want;
        end else begin
          $error("directed row %0d: frame not recognised by the predictor", k);
          mismatch_count++;
        end
      end
    end
    send_overlap_pair();

    // Random phases, one polarity mask each; the last runs without idling
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       mask = '0;
        1:       mask = '1;
        default: mask = MOTOR_COUNT'($urandom);
      endcase
      if (p == PHASE_COUNT - 1) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      reprogram(mask);
      goal = bytes_taken + PHASE_BYTES;
      while (bytes_taken < goal) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_frame(rand_payload(), FRM_GOOD, FRAME_LEN);
        end else if (r < 75) begin
          send_overlap_pair();
        end else if (r < 82) begin
          send_frame(rand_payload(), frame_kind_e'($urandom_range(1, 3)), FRAME_LEN);
        end else if (r < 87) begin
          send_frame(rand_payload(), FRM_GOOD, $urandom_range(1, FRAME_LEN - 1));
        end else begin
          // noise rich in marker bytes
          repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 7))
              0:       send_byte(HEAD_0);
              1:       send_byte(HEAD_1);
              2:       send_byte(TAIL_0);
              3:       send_byte(TAIL_1);
              default: send_byte(8'($urandom));
            endcase
          end
        end
        // hold the stream until every command has drained
        if (gaps_on && $urandom_range(0, 24) == 0) begin
          rx_bus.valid <= 1'b0;
          wait_drained();
          @(negedge clk);
        end
      end
    end

    rx_bus.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d bytes and %0d decoded commands over %0d polarity masks",
             bytes_taken, frames_checked, mask_writes + 1);
    $display("directed frames: %0d rows plus an overlapping pair; %0d mismatches",
             $size(directed_rows), mismatch_count);
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
